/* hdl/mku_pkg.sv */
package mku_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned IdxW  = 5;
  localparam int unsigned ElemW = 3;
  localparam int unsigned MaxElems = 6;

  localparam logic [1:0] KIND_MORSE   = 2'd0;
  localparam logic [1:0] KIND_SPACE   = 2'd1;
  localparam logic [1:0] KIND_UNKNOWN = 2'd2;

  // One classified character. Bit i of dashes is element i, 1 for a dah.
  typedef struct packed {
    logic [1:0]          kind;
    logic [ElemW-1:0]    nelem;
    logic [MaxElems-1:0] dashes;
  } desc_t;

  function automatic desc_t mk_code(input logic [ElemW-1:0] n,
                                    input logic [MaxElems-1:0] d);
    desc_t r;
    r.kind   = KIND_MORSE;
    r.nelem  = n;
    r.dashes = d;
    return r;
  endfunction

  function automatic desc_t classify(input logic [CharW-1:0] ch_in);
    logic [CharW-1:0] ch;
    desc_t r;
    ch = ch_in;
    if (ch >= "a" && ch <= "z") begin
      ch = ch - 8'd32;
    end
    r.kind   = KIND_UNKNOWN;
    r.nelem  = '0;
    r.dashes = '0;
    unique case (ch)
      " ": r.kind = KIND_SPACE;
      "A": r = mk_code(3'd2, 6'b000010);
      "B": r = mk_code(3'd4, 6'b000001);
      "C": r = mk_code(3'd4, 6'b000101);
      "D": r = mk_code(3'd3, 6'b000001);
      "E": r = mk_code(3'd1, 6'b000000);
      "F": r = mk_code(3'd4, 6'b000100);
      "G": r = mk_code(3'd3, 6'b000011);
      "H": r = mk_code(3'd4, 6'b000000);
      "I": r = mk_code(3'd2, 6'b000000);
      "J": r = mk_code(3'd4, 6'b001110);
      "K": r = mk_code(3'd3, 6'b000101);
      "L": r = mk_code(3'd4, 6'b000010);
      "M": r = mk_code(3'd2, 6'b000011);
      "N": r = mk_code(3'd2, 6'b000001);
      "O": r = mk_code(3'd3, 6'b000111);
      "P": r = mk_code(3'd4, 6'b000110);
      "Q": r = mk_code(3'd4, 6'b001011);
      "R": r = mk_code(3'd3, 6'b000010);
      "S": r = mk_code(3'd3, 6'b000000);
      "T": r = mk_code(3'd1, 6'b000001);
      "U": r = mk_code(3'd3, 6'b000100);
      "V": r = mk_code(3'd4, 6'b001000);
      "W": r = mk_code(3'd3, 6'b000110);
      "X": r = mk_code(3'd4, 6'b001001);
      "Y": r = mk_code(3'd4, 6'b001101);
      "Z": r = mk_code(3'd4, 6'b000011);
      "1": r = mk_code(3'd5, 6'b011110);
      "2": r = mk_code(3'd5, 6'b011100);
      "3": r = mk_code(3'd5, 6'b011000);
      "4": r = mk_code(3'd5, 6'b010000);
      "5": r = mk_code(3'd5, 6'b000000);
      "6": r = mk_code(3'd5, 6'b000001);
      "7": r = mk_code(3'd5, 6'b000011);
      "8": r = mk_code(3'd5, 6'b000111);
      "9": r = mk_code(3'd5, 6'b001111);
      "0": r = mk_code(3'd5, 6'b011111);
      ".": r = mk_code(3'd6, 6'b101010);
      ",": r = mk_code(3'd6, 6'b110011);
      "?": r = mk_code(3'd6, 6'b001100);
      "!": r = mk_code(3'd6, 6'b110101);
      "-": r = mk_code(3'd6, 6'b100001);
      "/": r = mk_code(3'd5, 6'b001001);
      "(": r = mk_code(3'd5, 6'b001101);
      ")": r = mk_code(3'd6, 6'b101101);
      default: r.kind = KIND_UNKNOWN;
    endcase
    return r;
  endfunction

endpackage

/* hdl/mku_front.sv */
module mku_front (
  input  logic [mku_pkg::CharW-1:0] char_code,
  output mku_pkg::desc_t            desc
);

  // Case folding and table lookup; the back end only sees element lists.
  assign desc = mku_pkg::classify(char_code);

endmodule

/* hdl/mku_queue.sv */
module mku_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mku_pkg::desc_t push_desc,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output mku_pkg::desc_t q_desc
);

  mku_pkg::desc_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full    = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_desc  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* hdl/mku_back.sv */
module mku_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  mku_pkg::desc_t           q_desc,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     lamp_on,
  output logic                     level_changed,
  output logic [mku_pkg::IdxW-1:0] unit_index,
  output logic                     last_unit
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_MARK = 3'd1;
  localparam logic [2:0] PH_GAP  = 3'd2;
  localparam logic [2:0] PH_TAIL = 3'd3;
  localparam logic [2:0] PH_FLAT = 3'd4;

  localparam logic [2:0] TailLast = 3'd2;
  localparam logic [2:0] FlatLast = 3'd6;
  localparam logic [2:0] DahLast  = 3'd2;

  logic [2:0]                  ph_r, ph_nxt;
  logic [2:0]                  cnt_r, cnt_nxt;
  logic [mku_pkg::ElemW-1:0]   elem_r, elem_nxt;
  logic [mku_pkg::IdxW-1:0]    idx_r, idx_nxt;
  mku_pkg::desc_t              desc_r;
  logic                        prev_r, prev_nxt;
  logic                        ov_r, ov_nxt;
  logic                        lamp_r, chg_r, last_r;
  logic [mku_pkg::IdxW-1:0]    oidx_r;

  logic can_emit;
  logic lvl;
  logic fin;
  logic dah;
  logic load;

  assign load     = (ph_r == PH_IDLE) && q_valid;
  assign q_pop    = load;
  assign can_emit = (ph_r != PH_IDLE) && (!ov_r || out_ready);
  assign dah      = desc_r.dashes[elem_r];
  assign lvl      = (ph_r == PH_MARK) ||
                    ((ph_r == PH_FLAT) && (desc_r.kind == mku_pkg::KIND_UNKNOWN));
  assign fin      = ((ph_r == PH_TAIL) && (cnt_r == TailLast)) ||
                    ((ph_r == PH_FLAT) && (cnt_r == FlatLast));

  always_comb begin
    ph_nxt   = ph_r;
    cnt_nxt  = cnt_r;
    elem_nxt = elem_r;
    idx_nxt  = idx_r;
    prev_nxt = prev_r;
    ov_nxt   = ov_r & ~out_ready;
    if (load) begin
      ph_nxt   = (q_desc.kind == mku_pkg::KIND_MORSE) ? PH_MARK : PH_FLAT;
      cnt_nxt  = 3'd0;
      elem_nxt = '0;
      idx_nxt  = '0;
    end else if (can_emit) begin
      ov_nxt   = 1'b1;
      prev_nxt = lvl;
      idx_nxt  = idx_r + 1'b1;
      cnt_nxt  = cnt_r + 3'd1;
      unique case (ph_r)
        PH_MARK: begin
          if (cnt_r == (dah ? DahLast : 3'd0)) begin
            cnt_nxt = 3'd0;
            ph_nxt  = (elem_r == desc_r.nelem - 1'b1) ? PH_TAIL : PH_GAP;
          end
        end
        PH_GAP: begin
          cnt_nxt  = 3'd0;
          elem_nxt = elem_r + 1'b1;
          ph_nxt   = PH_MARK;
        end
        PH_TAIL, PH_FLAT: begin
          if (fin) begin
            ph_nxt = PH_IDLE;
          end
        end
        default: ph_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      desc_r <= q_desc;
    end
    if (can_emit) begin
      lamp_r <= lvl;
      chg_r  <= lvl ^ prev_r;
      last_r <= fin;
      oidx_r <= idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      cnt_r  <= 3'd0;
      elem_r <= '0;
      idx_r  <= '0;
      prev_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      cnt_r  <= cnt_nxt;
      elem_r <= elem_nxt;
      idx_r  <= idx_nxt;
      prev_r <= prev_nxt;
      ov_r   <= ov_nxt;
    end
  end

  assign out_valid     = ov_r;
  assign lamp_on       = lamp_r;
  assign level_changed = chg_r;
  assign unit_index    = oidx_r;
  assign last_unit     = last_r;

endmodule

/* hdl/morse_unit_keyer_top.sv */
// Channel | Dir | Ports                                  | Contents
// in      | in  | in_tvalid, in_tready, in_tdata[7:0]    | one ASCII character per word
// out     | out | out_tvalid, out_tready, out_tdata[7:0], | one time unit per word
//         |     | out_tlast                              | tlast on the final unit
//
// A character gives 4 to 22 output words, one per cycle while the sink takes them;
// after its last unit the unit sequencer idles while it loads the next character
// from the two-word queue, so it does not start a character before the last is done.
// Reset is synchronous, active low; it empties the queue and clears the previous level.
// Input and output stall independently: the queue takes two characters ahead.
module morse_unit_keyer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] lamp_on, [1] level_changed, [6:2] unit_index, [7] zero
  output logic       out_tlast   // last_unit
);

  mku_pkg::desc_t            cls_desc;
  mku_pkg::desc_t            q_desc;
  logic                      q_full;
  logic                      q_valid;
  logic                      q_pop;
  logic                      lamp_on;
  logic                      level_changed;
  logic [mku_pkg::IdxW-1:0]  unit_index;

  mku_front u_front (
    .char_code (in_tdata),
    .desc      (cls_desc)
  );

  mku_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid && in_tready),
    .push_desc (cls_desc),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_desc    (q_desc)
  );

  mku_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_desc        (q_desc),
    .q_pop         (q_pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .lamp_on       (lamp_on),
    .level_changed (level_changed),
    .unit_index    (unit_index),
    .last_unit     (out_tlast)
  );

  assign in_tready = ~q_full;
  assign out_tdata = {1'b0, unit_index, level_changed, lamp_on};

  a_idx_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[6:2] <= 5'd21)
    else $error("unit index beyond the longest pattern");

  a_idx_step : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && out_tdata[6:2] == 5'($past(out_tdata[6:2]) + 5'd1))
    else $error("units of a character not sent back to back");

  a_new_char : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid || out_tdata[6:2] == 5'd0)
    else $error("next character does not start at its first unit");

  a_last_len : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[6:2] >= 5'd3)
    else $error("pattern shorter than four units");

endmodule
